// ===== hw/rtl/lfo_pan_pkg.sv =====
// ----------------------------------------------------------------------------
// lfo_pan_pkg
// Shared types, constants and operation codes for the auto panner.
// ----------------------------------------------------------------------------
package lfo_pan_pkg;

	localparam int unsigned SampleBitsDef     = 24;
	localparam int unsigned RandomHoldDef     = 200;
	localparam logic [31:0] NoiseSeed         = 32'hACE1ACE1;
	localparam logic [31:0] NoiseMask         = 32'h80200003;
	localparam logic [14:0] AmountCap         = 15'd26214;
	localparam logic [16:0] UnityQ15          = 17'd32768;
	localparam logic [7:0]  RandomStep        = 8'd131;

	localparam logic [2:0] RegPhaseStep   = 3'd0;
	localparam logic [2:0] RegPhaseOffset = 3'd1;
	localparam logic [2:0] RegWaveSelect  = 3'd2;
	localparam logic [2:0] RegPanAmount   = 3'd3;
	localparam logic [2:0] RegInvertPan   = 3'd4;
	localparam logic [2:0] RegStereoWidth = 3'd5;
	localparam logic [2:0] RegDryWetMix   = 3'd6;

	localparam logic [2:0] WaveSine     = 3'd0;
	localparam logic [2:0] WaveTriangle = 3'd1;
	localparam logic [2:0] WaveRampUp   = 3'd2;
	localparam logic [2:0] WaveRampDown = 3'd3;
	localparam logic [2:0] WaveRandom   = 3'd4;

	typedef struct packed {
		logic signed [SampleBitsDef-1:0] left_in;
		logic signed [SampleBitsDef-1:0] right_in;
	} pan_in_t;

	typedef struct packed {
		logic signed [SampleBitsDef-1:0] left_out;
		logic signed [SampleBitsDef-1:0] right_out;
	} pan_out_t;

	// sequencer steps, most of them driving one shared multiply
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_LFO,
		ST_RND,
		ST_SN_T2,
		ST_SN_I,
		ST_SN_O,
		ST_SN_S,
		ST_CAP,
		ST_POS,
		ST_U,
		ST_SR_T2,
		ST_SR_I,
		ST_SR_O,
		ST_SR_S,
		ST_SL_T2,
		ST_SL_I,
		ST_SL_O,
		ST_SL_S,
		ST_PAN_L,
		ST_PAN_R,
		ST_WID_L,
		ST_WID_R,
		ST_MIX_L,
		ST_MIX_R,
		ST_DONE
	} pan_state_t;

	// operands into the shared multiplier
	typedef struct packed {
		logic signed [40:0] a;
		logic signed [17:0] b;
	} mul_req_t;

endpackage

// ===== hw/rtl/lfo_pan_mul.sv =====
// ----------------------------------------------------------------------------
// lfo_pan_mul
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
module lfo_pan_mul
	import lfo_pan_pkg::*;
(
	input  logic               clk,
	input  mul_req_t           req,
	output logic signed [58:0] prod_q
);
	always_ff @(posedge clk) begin
		prod_q <= req.a * req.b;
	end
endmodule

// ===== hw/rtl/lfo_equal_power_auto_panner.sv =====
// each stereo pair runs the sequencer steps ST_LFO to ST_DONE, most of them using the
// shared multiplier; the random wave adds ST_RND and ST_CAP, and the sine adds
// ST_SN_T2 to ST_SN_S and ST_CAP; a new pair is taken only in ST_IDLE, after the
// last result is loaded; the output register is freed as soon as the result is taken
// arst_n clears phase and random state, seeds the noise register, loads register defaults
// ----------------------------------------------------------------------------
// lfo_equal_power_auto_panner
// LFO driven equal-power auto panner over a single shared multiplier.
// ----------------------------------------------------------------------------
module lfo_equal_power_auto_panner
	import lfo_pan_pkg::*;
#(
	parameter int unsigned RANDOM_HOLD_SAMPLES = RandomHoldDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  pan_in_t     in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output pan_out_t    out_data
);
	localparam int SB = SampleBitsDef;

	logic [19:0] phase_step_q;
	logic [31:0] phase_offset_q;
	logic [2:0]  wave_select_q;
	logic [14:0] pan_amount_q;
	logic        invert_pan_q;
	logic [15:0] stereo_width_q;
	logic [15:0] dry_wet_mix_q;

	logic [31:0]        lfo_phase_q;
	logic signed [15:0] random_target_q;
	logic signed [23:0] random_level_q;
	logic [7:0]         random_tick_q;
	logic [31:0]        noise_q;

	pan_state_t state_q, state_d;
	logic signed [SB-1:0] in_l_q, in_r_q;
	logic signed [17:0]   lfo_q;
	logic [16:0]          t_q, t2_q, u_q;
	logic [16:0]          gain_r_q;
	logic signed [SB+1:0] pan_l_q, pan_r_q, wet_l_q, wet_r_q;
	logic signed [SB+2:0] res_l_q;
	pan_out_t             out_q;
	logic                 out_valid_q;

	mul_req_t           mreq;
	logic signed [58:0] prod;

	lfo_pan_mul u_mul (.clk(clk), .req(mreq), .prod_q(prod));

	// derived combinational values
	logic [31:0] p;
	logic [15:0] h;
	logic [16:0] t_fold;
	logic [16:0] amount, width, mix;
	logic signed [SB:0]   mono;
	logic [31:0] noise_next;
	logic [7:0]  tick_inc;
	logic signed [40:0] delta;
	logic signed [23:0] level_next;
	logic signed [17:0] pos_c;
	logic signed [17:0] pos_neg;
	logic [16:0] u;
	logic [16:0] inner_c, outer_c;
	logic signed [58:0] prod_sh;
	logic        out_load;

	assign p      = lfo_phase_q + phase_offset_q;
	assign h      = p[30:15];
	assign t_fold = h[15] ? (17'h10000 - {1'b0, h}) : {1'b0, h};
	assign amount = {2'b0, (pan_amount_q > AmountCap) ? AmountCap : pan_amount_q};
	assign width  = ({1'b0, stereo_width_q} > UnityQ15) ? UnityQ15 : {1'b0, stereo_width_q};
	assign mix    = ({1'b0, dry_wet_mix_q} > UnityQ15) ? UnityQ15 : {1'b0, dry_wet_mix_q};
	assign mono   = (SB+1)'(($signed({in_l_q[SB-1], in_l_q}) + $signed({in_r_q[SB-1], in_r_q}))
		>>> 1);
	assign noise_next = noise_q[0] ? ((noise_q >> 1) ^ NoiseMask) : (noise_q >> 1);
	assign tick_inc   = random_tick_q + 8'd1;
	assign delta      = 41'(($signed({random_target_q, 8'd0})) - random_level_q);
	assign prod_sh    = prod >>> 15;
	assign level_next = 24'(random_level_q + (prod >>> 16));
	assign pos_c      = 18'(prod_sh);
	assign pos_neg    = invert_pan_q ? -pos_c : pos_c;
	assign u          = 17'((19'(pos_neg) + 19'sd32768) >>> 1);
	assign inner_c    = 17'd21167 - 17'(prod_sh);
	assign outer_c    = 17'd51472 - 17'(prod_sh);
	assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid && in_ready) state_d = ST_LFO;
			ST_LFO: begin
				unique case (wave_select_q)
					WaveRandom:                           state_d = ST_RND;
					WaveTriangle, WaveRampUp, WaveRampDown: state_d = ST_POS;
					default:                              state_d = ST_SN_T2;
				endcase
			end
			ST_RND:   state_d = ST_CAP;
			ST_SN_T2: state_d = ST_SN_I;
			ST_SN_I:  state_d = ST_SN_O;
			ST_SN_O:  state_d = ST_SN_S;
			ST_SN_S:  state_d = ST_CAP;
			ST_CAP:   state_d = ST_POS;
			ST_POS:   state_d = ST_U;
			ST_U:     state_d = ST_SR_T2;
			ST_SR_T2: state_d = ST_SR_I;
			ST_SR_I:  state_d = ST_SR_O;
			ST_SR_O:  state_d = ST_SR_S;
			ST_SR_S:  state_d = ST_SL_T2;
			ST_SL_T2: state_d = ST_SL_I;
			ST_SL_I:  state_d = ST_SL_O;
			ST_SL_O:  state_d = ST_SL_S;
			ST_SL_S:  state_d = ST_PAN_L;
			ST_PAN_L: state_d = ST_PAN_R;
			ST_PAN_R: state_d = ST_WID_L;
			ST_WID_L: state_d = ST_WID_R;
			ST_WID_R: state_d = ST_MIX_L;
			ST_MIX_L: state_d = ST_MIX_R;
			ST_MIX_R: state_d = ST_DONE;
			ST_DONE:  if (out_load) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// multiplier operand select; product is registered and used by the next step
	always_comb begin
		mreq = '0;
		unique case (state_q)
			ST_RND:   begin mreq.a = delta; mreq.b = 18'(RandomStep); end
			ST_POS:   begin mreq.a = 41'(lfo_q); mreq.b = 18'(amount); end
			ST_SN_T2, ST_SR_T2, ST_SL_T2: begin mreq.a = 41'(t_q); mreq.b = 18'(t_q); end
			ST_SN_I, ST_SR_I, ST_SL_I: begin mreq.a = 41'(prod_sh); mreq.b = 18'sd2463; end
			ST_SN_O, ST_SR_O, ST_SL_O: begin mreq.a = 41'(t2_q); mreq.b = 18'(inner_c); end
			ST_SN_S, ST_SR_S, ST_SL_S: begin mreq.a = 41'(t_q); mreq.b = 18'(outer_c); end
			ST_PAN_L: begin mreq.a = 41'(mono); mreq.b = 18'(prod_sh); end
			ST_PAN_R: begin mreq.a = 41'(mono); mreq.b = 18'(gain_r_q); end
			ST_WID_L: begin mreq.a = 41'(pan_l_q - in_l_q); mreq.b = 18'(width); end
			ST_WID_R: begin mreq.a = 41'(pan_r_q - in_r_q); mreq.b = 18'(width); end
			ST_MIX_L: begin mreq.a = 41'(wet_l_q - in_l_q); mreq.b = 18'(mix); end
			// held while the result waits so the last product stays put
			ST_MIX_R, ST_DONE: begin mreq.a = 41'(wet_r_q - in_r_q); mreq.b = 18'(mix); end
			default:  mreq = '0;
		endcase
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	function automatic logic signed [SB-1:0] sat(input logic signed [SB+2:0] v);
		logic signed [SB+2:0] hi, lo;
		hi = (SB+3)'((1 << (SB-1)) - 1);
		lo = -hi - 1;
		if (v > hi) return hi[SB-1:0];
		else if (v < lo) return lo[SB-1:0];
		else return v[SB-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q    <= 20'd89478;
			phase_offset_q  <= 32'h80000000;
			wave_select_q   <= WaveSine;
			pan_amount_q    <= 15'd16384;
			invert_pan_q    <= 1'b0;
			stereo_width_q  <= 16'd32768;
			dry_wet_mix_q   <= 16'd32768;
			lfo_phase_q     <= '0;
			random_target_q <= '0;
			random_level_q  <= '0;
			random_tick_q   <= '0;
			noise_q         <= NoiseSeed;
			state_q         <= ST_IDLE;
			out_valid_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					RegPhaseStep:   phase_step_q   <= cfg_data[19:0];
					RegPhaseOffset: phase_offset_q <= cfg_data;
					RegWaveSelect:  wave_select_q  <= cfg_data[2:0];
					RegPanAmount:   pan_amount_q   <= cfg_data[14:0];
					RegInvertPan:   invert_pan_q   <= cfg_data[0];
					RegStereoWidth: stereo_width_q <= cfg_data[15:0];
					RegDryWetMix:   dry_wet_mix_q  <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (state_q == ST_IDLE && in_valid) lfo_phase_q <= lfo_phase_q + 32'(phase_step_q);
			// random tick and target update, level step lands in ST_CAP
			if (state_q == ST_LFO && wave_select_q == WaveRandom) begin
				if (32'(tick_inc) >= RANDOM_HOLD_SAMPLES) begin
					random_tick_q   <= '0;
					noise_q         <= noise_next;
					random_target_q <= $signed(noise_next[31:16]);
				end else begin
					random_tick_q <= tick_inc;
				end
			end
			if (state_q == ST_CAP && wave_select_q == WaveRandom)
				random_level_q <= level_next;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				in_l_q <= in_data.left_in;
				in_r_q <= in_data.right_in;
			end
			ST_LFO: begin
				unique case (wave_select_q)
					WaveTriangle: lfo_q <= p[31] ? -18'(t_fold) : 18'(t_fold);
					WaveRampUp:   lfo_q <= 18'(p[31:16]) - 18'sd32768;
					WaveRampDown: lfo_q <= 18'sd32768 - 18'(p[31:16]);
					default:      lfo_q <= '0;
				endcase
				t_q <= t_fold;
			end
			ST_SN_I, ST_SR_I, ST_SL_I: t2_q <= 17'(prod_sh);
			ST_CAP: begin
				if (wave_select_q == WaveRandom)
					lfo_q <= 18'(level_next >>> 8);
				else
					lfo_q <= p[31] ? -18'(prod_sh) : 18'(prod_sh);
			end
			ST_U: begin
				t_q <= u;
				u_q <= u;
			end
			ST_SR_S:  t_q <= UnityQ15 - u_q;
			ST_SL_T2: gain_r_q <= 17'(prod_sh);
			ST_PAN_R: pan_l_q <= (SB+2)'(prod_sh);
			ST_WID_L: pan_r_q <= (SB+2)'(prod_sh);
			ST_WID_R: wet_l_q <= (SB+2)'(in_l_q + prod_sh);
			ST_MIX_L: wet_r_q <= (SB+2)'(in_r_q + prod_sh);
			ST_MIX_R: res_l_q <= (SB+3)'(in_l_q + prod_sh);
			ST_DONE: begin
				if (out_load) begin
					out_q.left_out  <= sat(res_l_q);
					out_q.right_out <= sat((SB+3)'(in_r_q + prod_sh));
				end
			end
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n) out_valid && !out_ready |=> out_valid)
		else $error("result dropped");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("result changed while waiting");
	assert property (@(posedge clk) disable iff (!arst_n) in_valid && in_ready |=> !in_ready)
		else $error("second request during work");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) && (!out_valid || out_ready) |=> out_valid)
		else $error("no result after last step");
endmodule
